FILE: rtl/hmd4_pkg.sv
package hmd4_pkg;

  localparam logic [31:0] SEED0 = 32'h67452301;
  localparam logic [31:0] SEED1 = 32'hefcdab89;
  localparam logic [31:0] SEED2 = 32'h98badcfe;
  localparam logic [31:0] SEED3 = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;

  localparam int NUM_STEPS = 24;
  localparam logic [4:0] LAST_STEP = 5'd23;

  // One packed chunk as handed from the byte packer to the transform engine.
  typedef struct packed {
    logic [7:0][31:0] words;
    logic             last;   // closes the message: emit the hash after it
    logic             empty;  // zero-length message: emit the seed words only
  } hmd4_chunk_t;

  typedef struct packed {
    logic pop;
    logic emit_seed;
    logic emit_end;
  } hmd4_back_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } hmd4_back_state_t;

  function automatic logic [2:0] word_sel(input logic [4:0] k);
    logic [2:0] w;
    case (k)
      5'd0:  w = 3'd0;
      5'd1:  w = 3'd1;
      5'd2:  w = 3'd2;
      5'd3:  w = 3'd3;
      5'd4:  w = 3'd4;
      5'd5:  w = 3'd5;
      5'd6:  w = 3'd6;
      5'd7:  w = 3'd7;
      5'd8:  w = 3'd1;
      5'd9:  w = 3'd3;
      5'd10: w = 3'd5;
      5'd11: w = 3'd7;
      5'd12: w = 3'd0;
      5'd13: w = 3'd2;
      5'd14: w = 3'd4;
      5'd15: w = 3'd6;
      5'd16: w = 3'd3;
      5'd17: w = 3'd7;
      5'd18: w = 3'd2;
      5'd19: w = 3'd6;
      5'd20: w = 3'd1;
      5'd21: w = 3'd5;
      5'd22: w = 3'd0;
      5'd23: w = 3'd4;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [4:0] k);
    logic [4:0] s;
    if (k < 5'd8) begin
      case (k[1:0])
        2'd0: s = 5'd3;
        2'd1: s = 5'd7;
        2'd2: s = 5'd11;
        default: s = 5'd19;
      endcase
    end else if (k < 5'd16) begin
      case (k[1:0])
        2'd0: s = 5'd3;
        2'd1: s = 5'd5;
        2'd2: s = 5'd9;
        default: s = 5'd13;
      endcase
    end else begin
      case (k[1:0])
        2'd0: s = 5'd3;
        2'd1: s = 5'd9;
        2'd2: s = 5'd11;
        default: s = 5'd15;
      endcase
    end
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [5:0] rs;
    rs = 6'd32 - {1'b0, s};
    return (x << s) | (x >> rs);
  endfunction

endpackage

FILE: rtl/hmd4_front.sv
module hmd4_front import hmd4_pkg::*; #(
  parameter int LW = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_message_length,
  input  logic        in_last_byte,
  input  logic        q_full,
  output logic        push,
  output hmd4_chunk_t push_data
);

  logic [LW-1:0]    rem_r, rem_nxt;
  logic [4:0]       pos_r, pos_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [31:0]      pad_r, pad_nxt;
  logic [7:0][31:0] words_r, words_nxt;

  logic          accept, idle, empty_msg, end_msg, close;
  logic [LW-1:0] len_m, rem_cur, rem_dec;
  logic [31:0]   rem_ext, pad_half, pad_cur, acc_base, sbyte;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign len_m     = in_message_length[LW-1:0];
  assign idle      = (rem_r == '0) && (pos_r == 5'd0);
  assign empty_msg = idle && (len_m == '0);
  assign rem_cur   = idle ? len_m : rem_r;
  assign rem_dec   = rem_cur - {{(LW-1){1'b0}}, 1'b1};
  assign end_msg   = in_last_byte || (rem_dec == '0);
  assign close     = end_msg || (pos_r == 5'd31);

  assign rem_ext  = 32'(rem_cur);
  assign pad_half = rem_ext | (rem_ext << 8);
  assign pad_cur  = (pos_r == 5'd0) ? (pad_half | (pad_half << 16)) : pad_r;
  assign acc_base = (pos_r[1:0] == 2'd0) ? pad_cur : acc_r;
  assign sbyte    = {{24{in_data_byte[7]}}, in_data_byte};
  assign acc_nxt  = (acc_base << 8) + sbyte;

  always_comb begin
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    pad_nxt   = pad_r;
    words_nxt = words_r;
    push      = 1'b0;
    push_data = '0;
    if (accept) begin
      if (empty_msg) begin
        push            = 1'b1;
        push_data.empty = 1'b1;
      end else begin
        pad_nxt = pad_cur;
        if (pos_r[1:0] == 2'd3) begin
          words_nxt[pos_r[4:2]] = acc_nxt;
        end
        rem_nxt = end_msg ? '0 : rem_dec;
        pos_nxt = close ? 5'd0 : pos_r + 5'd1;
        if (close) begin
          push           = 1'b1;
          push_data.last = end_msg;
          // finished words, then the word in progress, then pad
          for (int w = 0; w < 8; w++) begin
            if (3'(w) < pos_r[4:2]) begin
              push_data.words[w] = words_r[w];
            end else if (3'(w) == pos_r[4:2]) begin
              push_data.words[w] = acc_nxt;
            end else begin
              push_data.words[w] = pad_cur;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      pos_r <= 5'd0;
    end else begin
      rem_r <= rem_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !empty_msg) begin
      acc_r <= acc_nxt;
    end
    pad_r   <= pad_nxt;
    words_r <= words_nxt;
  end

endmodule

FILE: rtl/hmd4_queue.sv
module hmd4_queue import hmd4_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  hmd4_chunk_t push_data,
  input  logic        pop,
  output logic        q_valid,
  output logic        q_full,
  output hmd4_chunk_t q_head
);

  hmd4_chunk_t mem_r [2];
  logic [1:0]  count_r, count_nxt;
  logic        wr_r, rd_r;

  assign q_valid = (count_r != 2'd0);
  assign q_full  = (count_r == 2'd2);
  assign q_head  = mem_r[rd_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/hmd4_back.sv
module hmd4_back import hmd4_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  hmd4_chunk_t     q_head,
  output hmd4_back_stat_t stat,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_hash_major,
  output logic [31:0]     out_hash_minor
);

  hmd4_back_state_t state_r, state_nxt;
  logic [4:0]       step_r;
  logic [31:0]      a_r, b_r, c_r, d_r;
  logic [31:0]      chain_r [4];
  logic             out_valid_r;
  logic [31:0]      major_r, minor_r;

  logic        out_free, start, step_last, finish, adv;
  logic [31:0] f, kc, sum, new_w;

  assign out_free  = !out_valid_r || !out_stall;
  assign step_last = (step_r == LAST_STEP);

  // round function on the rotating registers
  always_comb begin
    if (step_r < 5'd8) begin
      f  = d_r ^ (b_r & (c_r ^ d_r));
      kc = 32'd0;
    end else if (step_r < 5'd16) begin
      f  = (b_r & c_r) + ((b_r ^ c_r) & d_r);
      kc = K_ROUND2;
    end else begin
      f  = b_r ^ c_r ^ d_r;
      kc = K_ROUND3;
    end
  end

  assign sum   = a_r + f + q_head.words[word_sel(step_r)] + kc;
  assign new_w = rotl32(sum, rot_amt(step_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && !q_head.empty) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (finish) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    start          = 1'b0;
    finish         = 1'b0;
    adv            = 1'b0;
    stat.pop       = 1'b0;
    stat.emit_seed = 1'b0;
    stat.emit_end  = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && q_head.empty && out_free) begin
          stat.pop       = 1'b1;
          stat.emit_seed = 1'b1;
        end
        start = q_valid && !q_head.empty;
      end
      BK_RUN: begin
        // hold the final step while the result register is taken
        finish        = step_last && (!q_head.last || out_free);
        adv           = !step_last || finish;
        stat.pop      = finish;
        stat.emit_end = finish && q_head.last;
      end
      default: begin
        start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      chain_r[0]  <= SEED0;
      chain_r[1]  <= SEED1;
      chain_r[2]  <= SEED2;
      chain_r[3]  <= SEED3;
    end else begin
      state_r <= state_nxt;
      if (stat.emit_seed || stat.emit_end) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (finish) begin
        if (q_head.last) begin
          chain_r[0] <= SEED0;
          chain_r[1] <= SEED1;
          chain_r[2] <= SEED2;
          chain_r[3] <= SEED3;
        end else begin
          chain_r[0] <= chain_r[0] + d_r;
          chain_r[1] <= chain_r[1] + new_w;
          chain_r[2] <= chain_r[2] + b_r;
          chain_r[3] <= chain_r[3] + c_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= chain_r[0];
      b_r    <= chain_r[1];
      c_r    <= chain_r[2];
      d_r    <= chain_r[3];
      step_r <= 5'd0;
    end else if (adv) begin
      a_r    <= d_r;
      b_r    <= new_w;
      c_r    <= b_r;
      d_r    <= c_r;
      step_r <= step_last ? 5'd0 : step_r + 5'd1;
    end
    if (stat.emit_seed) begin
      major_r <= SEED1;
      minor_r <= SEED2;
    end else if (stat.emit_end) begin
      major_r <= chain_r[1] + new_w;
      minor_r <= chain_r[2] + b_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_major = major_r;
  assign out_hash_minor = minor_r;

endmodule

FILE: rtl/half_md4_string_hash.sv
// Byte packer takes one byte per cycle unless the queue is full; each 32-byte
// chunk (or message tail) runs through a 24-step transform engine, behind a
// 2-chunk queue. A message's hash waits behind any chunks queued ahead of it.
// Long messages sustain one byte per cycle unless the output stalls; messages
// of n bytes need ceil(n / 32) passes of the transform engine, none if empty.
// Synchronous active-low reset clears the queue and reseeds the chain words.
module half_md4_string_hash import hmd4_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_message_length,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_major,
  output logic [31:0] out_hash_minor
);

  localparam int LW = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;

  logic            q_full, q_valid, push;
  hmd4_chunk_t     push_data, q_head;
  hmd4_back_stat_t bk_stat;

  hmd4_front #(.LW(LW)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_message_length (in_message_length),
    .in_last_byte      (in_last_byte),
    .q_full            (q_full),
    .push              (push),
    .push_data         (push_data)
  );

  hmd4_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (bk_stat.pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_head    (q_head)
  );

  hmd4_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .stat           (bk_stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_major (out_hash_major),
    .out_hash_minor (out_hash_minor)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("chunk pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.pop |-> q_valid) else $error("queue popped while empty");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_stat.emit_seed || bk_stat.emit_end) |=> out_valid)
    else $error("result lost on the way to the output register");

  a_emit_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_stat.emit_seed || bk_stat.emit_end) |-> bk_stat.pop)
    else $error("result emitted without retiring its chunk");

endmodule

FILE: tb/half_md4_string_hash_tb.sv
`timescale 1ns / 1ps

module half_md4_string_hash_tb;

  localparam logic [31:0] CHAIN_SEED0 = 32'h67452301;
  localparam logic [31:0] CHAIN_SEED1 = 32'hefcdab89;
  localparam logic [31:0] CHAIN_SEED2 = 32'h98badcfe;
  localparam logic [31:0] CHAIN_SEED3 = 32'h10325476;
  localparam logic [31:0] ROUND2_K    = 32'h5a827999;
  localparam logic [31:0] ROUND3_K    = 32'h6ed9eba1;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 600;

  typedef struct packed {
    logic [31:0] major;
    logic [31:0] minor;
  } hash_pair_t;

  // Tracks the chain words, chunk packing and pending hashes of the stream.
  class dirhash_checker;
    int step_word[24]  = '{0, 1, 2, 3, 4, 5, 6, 7,
                           1, 3, 5, 7, 0, 2, 4, 6,
                           3, 7, 2, 6, 1, 5, 0, 4};
    int step_shift[24] = '{3, 7, 11, 19, 3, 7, 11, 19,
                           3, 5, 9, 13, 3, 5, 9, 13,
                           3, 9, 11, 15, 3, 9, 11, 15};
    logic [31:0] chain[4];
    logic [31:0] chunk[8];
    logic [31:0] acc;
    logic [31:0] pad;
    logic [4:0]  pos;
    logic [15:0] remaining;
    hash_pair_t  hash_due_q[$];
    int          errors;

    function new();
      reseed();
      foreach (chunk[i]) chunk[i] = '0;
      acc = '0;
      pad = '0;
      pos = '0;
      remaining = '0;
      errors = 0;
    endfunction

    function void reseed();
      chain[0] = CHAIN_SEED0;
      chain[1] = CHAIN_SEED1;
      chain[2] = CHAIN_SEED2;
      chain[3] = CHAIN_SEED3;
    endfunction

    function void fold_chunk();
      logic [31:0] v[4];
      logic [31:0] x, y, z, f, kc, sum;
      int t;
      for (int i = 0; i < 4; i++) v[i] = chain[i];
      for (int k = 0; k < 24; k++) begin
        t = (4 - (k % 4)) % 4;
        x = v[(t + 1) % 4];
        y = v[(t + 2) % 4];
        z = v[(t + 3) % 4];
        if (k < 8) begin
          f = z ^ (x & (y ^ z));
          kc = '0;
        end else if (k < 16) begin
          f = (x & y) + ((x ^ y) & z);
          kc = ROUND2_K;
        end else begin
          f = x ^ y ^ z;
          kc = ROUND3_K;
        end
        sum = v[t] + f + chunk[step_word[k]] + kc;
        v[t] = (sum << step_shift[k]) | (sum >> (32 - step_shift[k]));
      end
      for (int i = 0; i < 4; i++) chain[i] = chain[i] + v[i];
    endfunction

    function void take_byte(logic [7:0] b, logic [15:0] len, logic last);
      logic [4:0]  p;
      logic [31:0] spread;
      logic        done;
      logic        full;
      int          n;
      if (remaining == 0 && pos == 0) begin
        // empty message: seed words, nothing else moves
        if (len == 0) begin
          hash_due_q.push_back(hash_pair_t'{chain[1], chain[2]});
          return;
        end
        remaining = len;
      end
      if (pos == 0) begin
        spread = {16'h0, remaining} | ({16'h0, remaining} << 8);
        pad = spread | (spread << 16);
      end
      p = pos;
      if (p[1:0] == 2'd0) acc = pad;
      acc = (acc << 8) + {{24{b[7]}}, b};
      if (p[1:0] == 2'd3) chunk[p[4:2]] = acc;
      remaining = remaining - 16'd1;
      done = last || (remaining == 0);
      full = (p == 5'd31);
      if (done || full) begin
        n = p + 1;
        if (n % 4 != 0) chunk[(n / 4) % 8] = acc;
        for (int w = (n + 3) / 4; w < 8; w++) chunk[w] = pad;
        fold_chunk();
        pos = '0;
      end else begin
        pos = p + 5'd1;
      end
      if (done) begin
        hash_due_q.push_back(hash_pair_t'{chain[1], chain[2]});
        reseed();
        remaining = '0;
        pos = '0;
        acc = '0;
        pad = '0;
      end
    endfunction

    function void check_hash(logic [31:0] major, logic [31:0] minor);
      hash_pair_t due;
      if (hash_due_q.size() == 0) begin
        $error("hash result with none expected: major %h minor %h", major, minor);
        errors++;
        return;
      end
      due = hash_due_q.pop_front();
      if (major !== due.major) begin
        $error("hash_major: expected %h, actual %h", due.major, major);
        errors++;
      end
      if (minor !== due.minor) begin
        $error("hash_minor: expected %h, actual %h", due.minor, minor);
        errors++;
      end
    endfunction

    function int pending();
      return hash_due_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic [15:0] in_message_length = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_hash_major;
  logic [31:0] out_hash_minor;

  dirhash_checker hash_check = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_armed = 1'b0;
  int bytes_sent = 0;
  int cycle_count = 0;

  half_md4_string_hash i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_message_length(in_message_length),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hash_major   (out_hash_major),
    .out_hash_minor   (out_hash_minor)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : result_side
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        hash_check.check_hash(out_hash_major, out_hash_minor);
      if (hold_armed && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      // long hold-off lets the block fill up and stall its input
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic [15:0] len, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_message_length <= len;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_check.take_byte(b, len, last);
    bytes_sent++;
  endtask

  // Length on later bytes is scrambled when jitter is set; the block must ignore it.
  task automatic send_message(input int unsigned len_field, input int unsigned count,
                              input bit mark_last, input bit jitter);
    logic [15:0] len;
    for (int unsigned i = 0; i < count; i++) begin
      len = (jitter && i != 0) ? 16'($urandom) : 16'(len_field);
      send_byte(8'($urandom), len, mark_last && (i == count - 1));
    end
  endtask

  task automatic send_random_message();
    int unsigned pick;
    int unsigned count;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_message(0, 1, 1'($urandom), 1'b0);
    end else if (pick < 70) begin
      count = ($urandom_range(0, 99) < 3) ? $urandom_range(256, 700) : $urandom_range(1, 70);
      send_message(count, count, 1'($urandom), 1'b0);
    end else if (pick < 85) begin
      // early end flag against a large declared length
      count = $urandom_range(1, 40);
      send_message($urandom_range(count, 65535), count, 1'b1, 1'b0);
    end else begin
      count = $urandom_range(1, 70);
      send_message(count, count, 1'($urandom), 1'b1);
    end
  endtask

  task automatic run_messages(input int target);
    while (bytes_sent < target) send_random_message();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (hash_check.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty messages, with and without the end flag, then a one-byte message
    send_byte(8'h5a, 16'd0, 1'b1);
    send_byte(8'hff, 16'd0, 1'b0);
    send_byte(8'h80, 16'd1, 1'b1);
    // ends on length alone, sign extension at the byte extremes
    send_byte(8'h7f, 16'd4, 1'b0);
    send_byte(8'h80, 16'd4, 1'b0);
    send_byte(8'h00, 16'd4, 1'b0);
    send_byte(8'hff, 16'd4, 1'b0);
    // overlapping pad bytes, early end
    send_byte(8'h01, 16'hffff, 1'b0);
    send_byte(8'hfe, 16'hffff, 1'b0);
    send_byte(8'h80, 16'hffff, 1'b1);
    // length changes mid-message
    send_byte(8'h12, 16'd300, 1'b0);
    send_byte(8'h34, 16'd0, 1'b0);
    send_byte(8'h56, 16'd7, 1'b0);
    send_byte(8'h78, 16'hffff, 1'b1);
    // end flag and length run out together
    send_byte(8'h00, 16'd2, 1'b0);
    send_byte(8'hff, 16'd2, 1'b1);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_messages(350);
    send_idle_pct = 48;
    run_messages(700);
    send_idle_pct = 0;
    recv_stall_pct = 48;
    run_messages(1050);
    send_idle_pct = 38;
    recv_stall_pct = 38;
    run_messages(1400);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_armed = 1'b1;
    run_messages(1550);
    wait_drained();

    send_idle_pct = 38;
    recv_stall_pct = 38;
    run_messages(1750);
    wait_drained();

    if (hash_check.pending() != 0) begin
      $error("hash results missing: %0d", hash_check.pending());
      hash_check.errors++;
    end
    if (hash_check.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
